/* hw/rtl/fpr_pkg.sv */
// fpr_pkg: shared types and constants for the fifo page replacement block
// no dependencies; imported by the controller, datapath and top level
package fpr_pkg;

   localparam int CFG_W        = 4;   // frames_in_use register width
   localparam int CFG_RESET    = 8;   // frames_in_use after reset
   localparam int FRAME_OUT_W  = 3;   // width of the frame_written field
   localparam int COUNT_W      = 32;  // fault counter width

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEND
   } fpr_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming page number
      logic execute;   // look up, replace and load the response register
      logic flush;     // take new frame count, invalidate all frames
   } fpr_cmd_type;

endpackage

/* hw/rtl/fpr_if.sv */
// fpr_if: valid/ready channel interfaces for request, response and csr write
// depends on fpr_pkg for field widths
interface fpr_req_if #(parameter int PAGE_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface fpr_rsp_if
   import fpr_pkg::*;
#(parameter int PAGE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [FRAME_OUT_W-1:0] frame_written;
   logic                   evicted_valid;
   logic [PAGE_BITS-1:0]   evicted_page;
   logic [COUNT_W-1:0]     fault_total;

   modport source (output valid, output hit, output frame_written, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input frame_written, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

interface fpr_csr_if
   import fpr_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/fpr_ctrl.sv */
// fpr_ctrl: sequencing state machine for the fifo page replacement block
// depends on fpr_pkg (state and command types)
module fpr_ctrl
   import fpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        csr_valid,
   output logic        csr_ready,
   output fpr_cmd_type cmd
);

   fpr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      csr_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            // csr write wins over a request in the same cycle
            csr_ready   = 1'b1;
            cmd.flush   = csr_valid;
            req_ready   = !csr_valid;
            cmd.capture = req_valid && !csr_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/fpr_datapath.sv */
// fpr_datapath: frame store, parallel page compare, fill pointer, fault counter
// and response register; depends on fpr_pkg, driven by fpr_ctrl commands
module fpr_datapath
   import fpr_pkg::*;
#(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fpr_cmd_type            cmd,
   input  logic [PAGE_BITS-1:0]   page_number,
   input  logic [CFG_W-1:0]       csr_data,
   output logic                   hit,
   output logic [FRAME_OUT_W-1:0] frame_written,
   output logic                   evicted_valid,
   output logic [PAGE_BITS-1:0]   evicted_page,
   output logic [COUNT_W-1:0]     fault_total
);

   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ACT_W     = $clog2(FRAMES + 1);
   localparam int ACT_RESET = (FRAMES < CFG_RESET) ? FRAMES : CFG_RESET;

   logic [PAGE_BITS-1:0]   page_ff;
   logic [PAGE_BITS-1:0]   frame_page_ff [FRAMES];
   logic [FRAMES-1:0]      frame_valid_ff, frame_valid_in;
   logic [IDX_W-1:0]       fill_ff, fill_in;
   logic [ACT_W-1:0]       active_ff, active_in;
   logic [COUNT_W-1:0]     fault_ff, fault_in;

   logic                   hit_ff, hit_in;
   logic [FRAME_OUT_W-1:0] frame_written_ff, frame_written_in;
   logic                   evicted_valid_ff, evicted_valid_in;
   logic [PAGE_BITS-1:0]   evicted_page_ff, evicted_page_in;
   logic [COUNT_W-1:0]     fault_total_ff, fault_total_in;

   logic [FRAMES-1:0]      match;
   logic                   any_hit;
   logic [IDX_W-1:0]       slot;
   logic [ACT_W:0]         slot_inc;
   logic [IDX_W+2:0]       slot_ext;
   logic                   write_frame;

   // frame count from the csr: zero acts as one, large values clamp to FRAMES
   always_comb begin
      if (csr_data == '0) begin
         active_in = ACT_W'(1);
      end else if (int'(csr_data) > FRAMES) begin
         active_in = ACT_W'(FRAMES);
      end else begin
         active_in = ACT_W'(csr_data);
      end
   end

   // compare against every frame at once
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         match[i] = frame_valid_ff[i] && (frame_page_ff[i] == page_ff) &&
                    (ACT_W'(i) < active_ff);
      end
      any_hit = |match;
   end

   always_comb begin
      if (ACT_W'(fill_ff) >= active_ff) begin
         slot = '0;
      end else begin
         slot = fill_ff;
      end
      slot_inc = (ACT_W + 1)'(slot) + 1'b1;
      if (slot_inc >= {1'b0, active_ff}) begin
         fill_in = '0;
      end else begin
         fill_in = IDX_W'(slot_inc);
      end
      slot_ext    = (IDX_W + 3)'(slot);
      write_frame = cmd.execute && !any_hit;
   end

   always_comb begin
      frame_valid_in = frame_valid_ff;
      fault_in       = fault_ff;
      if (cmd.flush) begin
         frame_valid_in = '0;
      end else if (write_frame) begin
         frame_valid_in[slot] = 1'b1;
         if (fault_ff != '1) fault_in = fault_ff + 1'b1;
      end
   end

   always_comb begin
      hit_in           = any_hit;
      frame_written_in = '0;
      evicted_valid_in = 1'b0;
      evicted_page_in  = '0;
      fault_total_in   = fault_in;
      if (!any_hit) begin
         frame_written_in = slot_ext[FRAME_OUT_W-1:0];
         evicted_valid_in = frame_valid_ff[slot];
         if (frame_valid_ff[slot]) evicted_page_in = frame_page_ff[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         fill_ff        <= '0;
         active_ff      <= ACT_W'(ACT_RESET);
         fault_ff       <= '0;
      end else begin
         frame_valid_ff <= frame_valid_in;
         fault_ff       <= fault_in;
         if (cmd.flush) begin
            fill_ff   <= '0;
            active_ff <= active_in;
         end else if (write_frame) begin
            fill_ff <= fill_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) page_ff <= page_number;
      if (write_frame) frame_page_ff[slot] <= page_ff;
      if (cmd.execute) begin
         hit_ff           <= hit_in;
         frame_written_ff <= frame_written_in;
         evicted_valid_ff <= evicted_valid_in;
         evicted_page_ff  <= evicted_page_in;
         fault_total_ff   <= fault_total_in;
      end
   end

   assign hit           = hit_ff;
   assign frame_written = frame_written_ff;
   assign evicted_valid = evicted_valid_ff;
   assign evicted_page  = evicted_page_ff;
   assign fault_total   = fault_total_ff;

endmodule

/* hw/rtl/fifo_page_replacement.sv */
// fifo_page_replacement: top level, joins fpr_ctrl and fpr_datapath
// depends on fpr_pkg and the channel interfaces in fpr_if
//
// usage
//   req_ch : one page reference per request (page_number)
//   rsp_ch : one response per request: hit, frame_written, evicted_valid,
//            evicted_page and the saturating fault_total
//   csr_ch : write of frames_in_use; flushes every frame and the fill
//            pointer, keeps the fault count
// timing
//   a request is taken in idle, looked up against all frames in parallel on
//   the next cycle and the response is offered on the cycle after that;
//   one request in flight at a time, so the block takes no new request until
//   the response to the last one is accepted, following the idle/execute/send
//   sequence of the controller
//   while the response is held (rsp_ready low) no new request is taken
// reset
//   synchronous and active high: all frames empty, fill pointer 0, fault
//   count 0, frames_in_use 8 (clamped to FRAMES)
module fifo_page_replacement
   import fpr_pkg::*;
#(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic   clock,
   input  logic   reset,
   fpr_req_if.sink   req_ch,
   fpr_rsp_if.source rsp_ch,
   fpr_csr_if.sink   csr_ch
);

   fpr_cmd_type cmd;

   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .cmd       (cmd)
   );

   fpr_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .page_number   (req_ch.page_number),
      .csr_data      (csr_ch.data),
      .hit           (rsp_ch.hit),
      .frame_written (rsp_ch.frame_written),
      .evicted_valid (rsp_ch.evicted_valid),
      .evicted_page  (rsp_ch.evicted_page),
      .fault_total   (rsp_ch.fault_total)
   );

endmodule

/* hw/rtl/fpr_checker.sv */
// fpr_checker: port level assertions for fifo_page_replacement, with its bind
// depends on fpr_pkg for field widths
module fpr_checker
   import fpr_pkg::*;
#(
   parameter int PAGE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   hit,
   input logic [FRAME_OUT_W-1:0] frame_written,
   input logic                   evicted_valid,
   input logic [PAGE_BITS-1:0]   evicted_page,
   input logic [COUNT_W-1:0]     fault_total
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(frame_written) &&
         $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_total))
      else $error("response changed while stalled");

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hit |-> frame_written == '0 && !evicted_valid && evicted_page == '0)
      else $error("hit response carries replacement fields");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !evicted_valid |-> evicted_page == '0)
      else $error("evicted page set without eviction");

endmodule

bind fifo_page_replacement fpr_checker #(.PAGE_BITS(PAGE_BITS)) u_fpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .hit           (rsp_ch.hit),
   .frame_written (rsp_ch.frame_written),
   .evicted_valid (rsp_ch.evicted_valid),
   .evicted_page  (rsp_ch.evicted_page),
   .fault_total   (rsp_ch.fault_total)
);

/* dv/fifo_page_replacement_test.sv */
// fifo_page_replacement_test: self-checking bench for the fifo page replacement unit
// depends on fpr_pkg, the channel interfaces in fpr_if and the fifo_page_replacement rtl
// page requests and frame-count writes are checked against a frame-table predictor
module fifo_page_replacement_test;
   import fpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAMES            = 8;
   localparam int PAGE_BITS         = 16;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int SETTLE_CYCLES     = 5;
   localparam int REFS_PER_SETTING  = 79;
   localparam int STEADY_SETTING    = 5;
   localparam int N_SETTINGS        = 12;
   localparam logic [CFG_W-1:0] FRAME_SWEEP [N_SETTINGS] =
      '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd12};

   typedef struct packed {
      logic                   hit;
      logic [FRAME_OUT_W-1:0] frame_written;
      logic                   evicted_valid;
      logic [PAGE_BITS-1:0]   evicted_page;
      logic [COUNT_W-1:0]     fault_total;
   } page_outcome_type;

   logic clock;
   logic reset;
   logic no_stall = 1'b0;

   fpr_req_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
   fpr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_ch ();
   fpr_csr_if                          csr_ch ();

   fifo_page_replacement #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor copy of the frame table
   logic [PAGE_BITS-1:0] frame_tag [FRAMES];
   logic [FRAMES-1:0]    frame_resident = '0;
   int unsigned          fill_slot      = 0;
   logic [COUNT_W-1:0]   faults_seen    = '0;
   logic [CFG_W-1:0]     frame_setting  = CFG_W'(CFG_RESET);

   logic [PAGE_BITS-1:0] page_backlog [$];
   page_outcome_type     outcome_queue [$];

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned checked_count  = 0;
   int unsigned hit_count      = 0;
   int unsigned setting_count  = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic resolve_reference(input logic [PAGE_BITS-1:0] page,
                                    output page_outcome_type outcome);
      int unsigned active;
      int unsigned slot;
      bit          found;
      active  = (frame_setting == 0) ? 1 :
                (frame_setting > FRAMES) ? FRAMES : frame_setting;
      found   = 1'b0;
      outcome = '0;
      for (int i = 0; i < active; i++) begin
         if (frame_resident[i] && frame_tag[i] == page) found = 1'b1;
      end
      if (found) begin
         outcome.hit         = 1'b1;
         outcome.fault_total = faults_seen;
      end else begin
         if (faults_seen != '1) faults_seen = faults_seen + 1'b1;
         slot = (fill_slot >= active) ? 0 : fill_slot;
         if (frame_resident[slot]) begin
            outcome.evicted_valid = 1'b1;
            outcome.evicted_page  = frame_tag[slot];
         end
         frame_tag[slot]      = page;
         frame_resident[slot] = 1'b1;
         fill_slot            = (slot + 1 >= active) ? 0 : slot + 1;
         outcome.frame_written = FRAME_OUT_W'(slot);
         outcome.fault_total   = faults_seen;
      end
   endtask

   function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                       logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (page_backlog.size() != 0 && (no_stall || $urandom_range(99) >= 11)) begin
            req_ch.valid       <= 1'b1;
            req_ch.page_number <= page_backlog.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && (no_stall || $urandom_range(99) >= 11);
   end

   // monitor: frame-count writes, response checks, then prediction of new requests
   always @(posedge clock) begin
      page_outcome_type want;
      page_outcome_type predicted;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            frame_setting  = csr_ch.data;
            frame_resident = '0;
            fill_slot      = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_queue.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = outcome_queue.pop_front();
               check_field("hit", COUNT_W'(want.hit), COUNT_W'(rsp_ch.hit));
               check_field("frame_written", COUNT_W'(want.frame_written),
                           COUNT_W'(rsp_ch.frame_written));
               check_field("evicted_valid", COUNT_W'(want.evicted_valid),
                           COUNT_W'(rsp_ch.evicted_valid));
               check_field("evicted_page", COUNT_W'(want.evicted_page),
                           COUNT_W'(rsp_ch.evicted_page));
               check_field("fault_total", want.fault_total, rsp_ch.fault_total);
               checked_count++;
               if (want.hit) hit_count++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            resolve_reference(req_ch.page_number, predicted);
            outcome_queue = {outcome_queue, predicted};
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d responses outstanding",
                  cycle_count, outcome_queue.size());
         $display("[fifo_page_replacement] ERROR");
         $finish;
      end
   end

   // wait until every request has gone through and every response is back
   task automatic wait_drained();
      @(negedge clock);
      while (page_backlog.size() != 0 || req_ch.valid || outcome_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [CFG_W-1:0] frames);
      wait_drained();
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= frames;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      setting_count++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [PAGE_BITS-1:0] page_pool [$];
      int unsigned          pool_len;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.page_number = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default eight frames: fill in order, hits, then oldest-first eviction
      page_backlog = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0004,
                       16'h5555, 16'hAAAA, 16'h8000, 16'hFFFF, 16'h1234, 16'h0000};
      // zero frames behaves as a single frame
      write_frame_count(4'd0);
      page_backlog = '{16'h0007, 16'h0007, 16'h0009, 16'h0007};
      // oversized count clamps to all frames, flush empties the table
      write_frame_count(4'd15);
      page_backlog = '{16'h0007, 16'h0009, 16'h0007};

      for (int s = 0; s < N_SETTINGS; s++) begin
         write_frame_count(FRAME_SWEEP[s]);
         no_stall = (s == STEADY_SETTING);
         // a small working set so that hits, fills and evictions all occur
         page_pool.delete();
         pool_len = $urandom_range(12, 3);
         repeat (pool_len) page_pool = {page_pool, PAGE_BITS'($urandom)};
         repeat (REFS_PER_SETTING) begin
            if ($urandom_range(99) < 85)
               page_backlog = {page_backlog, page_pool[$urandom_range(pool_len - 1, 0)]};
            else
               page_backlog = {page_backlog, PAGE_BITS'($urandom_range(65535, 0))};
         end
      end

      wait_drained();
      no_stall = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d page requests checked (%0d hits, %0d faults) over %0d frame counts",
               checked_count, hit_count, checked_count - hit_count, setting_count);
      if (mismatch_count == 0)
         $display("[fifo_page_replacement] OK");
      else
         $display("[fifo_page_replacement] ERROR");
      $finish;
   end

endmodule
